// ----- src/hla_pkg.sv -----
package hla_pkg;

    // default number of fraction bits for the fixed point datapath
    localparam int FRAC_BITS_DEF = 16;

    // register indexes on the configuration port
    localparam logic REG_MODE   = 1'b0;
    localparam logic REG_AMOUNT = 1'b1;

    // lightness change selected by the mode register
    typedef enum logic [1:0] {
        MODE_SET     = 2'd0,
        MODE_DARKEN  = 2'd1,
        MODE_LIGHTEN = 2'd2,
        MODE_KEEP    = 2'd3
    } mode_t;

    // segment of the hue wheel for one channel
    typedef enum logic [1:0] {
        SEG_RISE = 2'd0,
        SEG_TOP  = 2'd1,
        SEG_FALL = 2'd2,
        SEG_LOW  = 2'd3
    } seg_t;

    // one restoring division step: returns {quotient bit, new remainder}
    function automatic logic [11:0] div_step(input logic [11:0] rem, input logic [10:0] den);
        logic       ge;
        logic [11:0] diff;
        ge   = (rem >= {1'b0, den});
        diff = rem - {1'b0, den};
        return ge ? {1'b1, diff[10:0]} : {1'b0, rem[10:0]};
    endfunction

endpackage

// ----- src/hla_div.sv -----
module hla_div #(
    parameter int FRAC_BITS = hla_pkg::FRAC_BITS_DEF
) (
    input  logic                 clk,
    input  logic [FRAC_BITS:0]   en,
    input  logic [7:0]           sat_num,
    input  logic [8:0]           sat_den,
    input  logic [10:0]          hue_num,
    input  logic [10:0]          hue_den,
    input  logic                 grey,
    output logic [FRAC_BITS:0]   sat_quo,
    output logic [FRAC_BITS:0]   hue_quo,
    output logic                 grey_out
);

    localparam int NS = FRAC_BITS + 1;

    logic [10:0]        rem_reg [NS][2];
    logic [10:0]        den_reg [NS][2];
    logic [FRAC_BITS:0] quo_reg [NS][2];
    logic [NS-1:0]      grey_reg;

    logic [11:0]        rem_in  [NS][2];
    logic [10:0]        den_in  [NS][2];
    logic [FRAC_BITS:0] quo_in  [NS][2];
    logic [10:0]        rem_next [NS][2];
    logic [FRAC_BITS:0] quo_next [NS][2];

    // stage inputs: first stage from ports, later ones from the previous stage
    always_comb
    begin
        rem_in[0][0] = {4'b0, sat_num};
        den_in[0][0] = {2'b0, sat_den};
        rem_in[0][1] = {1'b0, hue_num};
        den_in[0][1] = hue_den;
        for (int l = 0; l < 2; l++)
        begin
            quo_in[0][l] = '0;
        end
        for (int k = 1; k < NS; k++)
        begin
            for (int l = 0; l < 2; l++)
            begin
                rem_in[k][l] = {rem_reg[k-1][l], 1'b0};
                den_in[k][l] = den_reg[k-1][l];
                quo_in[k][l] = quo_reg[k-1][l];
            end
        end
    end

    // one quotient bit per stage, msb first
    always_comb
    begin
        logic [11:0] res;
        res = '0;
        for (int k = 0; k < NS; k++)
        begin
            for (int l = 0; l < 2; l++)
            begin
                res = hla_pkg::div_step(rem_in[k][l], den_in[k][l]);
                rem_next[k][l] = res[10:0];
                quo_next[k][l] = quo_in[k][l];
                quo_next[k][l][FRAC_BITS-k] = res[11];
            end
        end
    end

    // stage registers
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NS; k++)
        begin
            if (en[k])
            begin
                for (int l = 0; l < 2; l++)
                begin
                    rem_reg[k][l] <= rem_next[k][l];
                    den_reg[k][l] <= den_in[k][l];
                    quo_reg[k][l] <= quo_next[k][l];
                end
            end
        end
        if (en[0])
        begin
            grey_reg[0] <= grey;
        end
        for (int k = 1; k < NS; k++)
        begin
            if (en[k])
            begin
                grey_reg[k] <= grey_reg[k-1];
            end
        end
    end

    assign sat_quo  = quo_reg[NS-1][0];
    assign hue_quo  = quo_reg[NS-1][1];
    assign grey_out = grey_reg[NS-1];

endmodule

// ----- src/hsl_lightness_adjust.sv -----
// channel   direction  handshake              payload
// in        sink       in_valid / in_stall    red_in, green_in, blue_in
// out       source     out_valid / out_stall  red_out, green_out, blue_out
// config    apb slave  psel / penable         paddr, pwdata, prdata
//
// one request per cycle sustained while the output is not stalled
// pipeline depth is set by the bit-per-stage dividers for saturation and hue
// reset clears all valid bits and both registers; no clearing pass
// a stalled output freezes only full stages, bubbles ahead of it still close up
module hsl_lightness_adjust #(
    parameter int FRAC_BITS = hla_pkg::FRAC_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  red_in,
    input  logic [7:0]  green_in,
    input  logic [7:0]  blue_in,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  red_out,
    output logic [7:0]  green_out,
    output logic [7:0]  blue_out
);

    localparam int FB      = FRAC_BITS;
    localparam int NS      = FB + 1;
    localparam int NST     = NS + 6;
    localparam int SA      = NS + 1;
    localparam int SB      = NS + 2;
    localparam int SC      = NS + 3;
    localparam int SD      = NS + 4;
    localparam int SE      = NS + 5;
    localparam int AMT_UP   = (FB >= 16) ? (FB - 16) : 0;
    localparam int AMT_DOWN = (FB < 16) ? (16 - FB) : 0;
    localparam logic [FB+1:0] ONE   = (FB+2)'(1) << FB;
    localparam logic [FB+1:0] HALF  = ONE / 2;
    localparam logic [FB+1:0] THIRD = ONE / 3;
    localparam logic [FB+1:0] TWO3  = (2 * ONE) / 3;
    localparam logic [FB+1:0] SIXTH = ONE / 6;
    localparam logic [FB:0]   LT_A  = (FB+1)'((1 << (FB - 1)) / 255);
    localparam logic [7:0]    LT_B  = 8'((1 << (FB - 1)) % 255);
    localparam logic [17:0]   LT_M  = 18'd131587;

    // configuration registers
    hla_pkg::mode_t mode_reg;
    logic [16:0]    amount_reg;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= hla_pkg::MODE_SET;
            amount_reg <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[2] == hla_pkg::REG_MODE)
            begin
                mode_reg <= hla_pkg::mode_t'(pwdata[1:0]);
            end
            else
            begin
                amount_reg <= pwdata[16:0];
            end
        end
    end

    always_comb
    begin
        if (paddr[2] == hla_pkg::REG_MODE)
        begin
            prdata = {30'b0, mode_reg};
        end
        else
        begin
            prdata = {15'b0, amount_reg};
        end
    end

    // valid bits and stage enables; a stage moves when empty or when the next one moves
    logic [NST-1:0] valid_reg;
    logic [NST-1:0] en;

    always_comb
    begin
        en[NST-1] = !valid_reg[NST-1] || !out_stall;
        for (int i = NST - 2; i >= 0; i--)
        begin
            en[i] = !valid_reg[i] || en[i+1];
        end
    end

    assign in_stall  = !en[0];
    assign out_valid = valid_reg[NST-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int i = 1; i < NST; i++)
            begin
                if (en[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    // stage 0: max, min, divider operands
    logic [7:0]  mx, mn, dd;
    logic [8:0]  sum;
    logic [8:0]  sat_den_c;
    logic [10:0] num_c, d11;

    always_comb
    begin
        mx = red_in;
        mn = red_in;
        if (green_in > mx) mx = green_in;
        if (blue_in > mx)  mx = blue_in;
        if (green_in < mn) mn = green_in;
        if (blue_in < mn)  mn = blue_in;
        dd  = mx - mn;
        sum = {1'b0, mx} + {1'b0, mn};
        d11 = {3'b0, dd};
        sat_den_c = (sum > 9'd255) ? (9'd510 - sum) : sum;
        if (mx == red_in)
        begin
            if (green_in >= blue_in)
                num_c = {3'b0, green_in} - {3'b0, blue_in};
            else
                num_c = (d11 << 2) + (d11 << 1) - ({3'b0, blue_in} - {3'b0, green_in});
        end
        else if (mx == green_in)
        begin
            num_c = (d11 << 1) + {3'b0, blue_in} - {3'b0, red_in};
        end
        else
        begin
            num_c = (d11 << 2) + {3'b0, red_in} - {3'b0, green_in};
        end
    end

    logic [8:0]  lt_num_reg, sat_den_reg;
    logic [7:0]  sat_num_reg;
    logic [10:0] hue_num_reg, hue_den_reg;
    logic        grey_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            lt_num_reg  <= sum;
            sat_num_reg <= dd;
            sat_den_reg <= sat_den_c;
            hue_num_reg <= num_c;
            hue_den_reg <= (d11 << 2) + (d11 << 1);
            grey_reg    <= (dd == 8'd0);
        end
    end

    // saturation and hue dividers
    logic [FB:0] lt_quo, sat_quo, hue_quo;
    logic        grey_q;

    hla_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk      (clk),
        .en       (en[NS:1]),
        .sat_num  (sat_num_reg),
        .sat_den  (sat_den_reg),
        .hue_num  (hue_num_reg),
        .hue_den  (hue_den_reg),
        .grey     (grey_reg),
        .sat_quo  (sat_quo),
        .hue_quo  (hue_quo),
        .grey_out (grey_q)
    );

    // lightness: sum / 510 as sum * a + (sum * b) / 255, the last part by reciprocal
    // multiply, then delayed to line up with the dividers
    logic [FB+9:0] lt_base_w;
    logic [16:0]   lt_z_w;
    logic [34:0]   lt_q_w;
    logic [FB:0]   lt_base_reg;
    logic [16:0]   lt_z_reg;
    logic [FB:0]   lt_dly_reg [NS-1];

    assign lt_base_w = lt_num_reg * LT_A;
    assign lt_z_w    = lt_num_reg * LT_B;
    assign lt_q_w    = lt_z_reg * LT_M;

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            lt_base_reg <= lt_base_w[FB:0];
            lt_z_reg    <= lt_z_w;
        end
        if (en[2])
        begin
            lt_dly_reg[0] <= lt_base_reg + (FB+1)'(lt_q_w[34:25]);
        end
        for (int k = 1; k < NS - 1; k++)
        begin
            if (en[k+2])
            begin
                lt_dly_reg[k] <= lt_dly_reg[k-1];
            end
        end
    end

    assign lt_quo = lt_dly_reg[NS-2];

    // stage a: amount scaling and new lightness
    logic [40:0]       amt_wide;
    logic [16:0]       amt_sat;
    logic [FB:0]       amt;
    logic [2*FB+1:0]   dark_prod, light_prod;
    logic [FB+1:0]     nl_c;
    logic [FB:0]       one_n;

    assign one_n = ONE[FB:0];

    always_comb
    begin
        amt_sat    = (amount_reg > 17'd65536) ? 17'd65536 : amount_reg;
        amt_wide   = ({24'b0, amt_sat} << AMT_UP) >> AMT_DOWN;
        amt        = amt_wide[FB:0];
        dark_prod  = lt_quo * (one_n - amt);
        light_prod = (one_n - lt_quo) * amt;
        case (mode_reg)
            hla_pkg::MODE_SET:     nl_c = {1'b0, amt};
            hla_pkg::MODE_DARKEN:  nl_c = dark_prod[2*FB+1:FB];
            hla_pkg::MODE_LIGHTEN: nl_c = {1'b0, lt_quo} + light_prod[2*FB+1:FB];
            default:               nl_c = {1'b0, lt_quo};
        endcase
        if (nl_c > ONE)
            nl_c = ONE;
    end

    logic [FB:0]   nl_a_reg, sat_a_reg;
    logic [FB-1:0] hue_a_reg;

    always_ff @(posedge clk)
    begin
        if (en[SA])
        begin
            nl_a_reg  <= nl_c[FB:0];
            sat_a_reg <= grey_q ? '0 : sat_quo;
            hue_a_reg <= (grey_q || hue_quo == one_n) ? '0 : hue_quo[FB-1:0];
        end
    end

    // stage b: lightness times saturation
    logic [2*FB+1:0] ls_prod;
    logic [FB:0]     m_b_reg, nl_b_reg, sat_b_reg;
    logic [FB-1:0]   hue_b_reg;

    assign ls_prod = nl_a_reg * sat_a_reg;

    always_ff @(posedge clk)
    begin
        if (en[SB])
        begin
            m_b_reg   <= ls_prod[2*FB:FB];
            nl_b_reg  <= nl_a_reg;
            sat_b_reg <= sat_a_reg;
            hue_b_reg <= hue_a_reg;
        end
    end

    // stage c: q, p and the three hue offsets
    logic [FB+2:0] q_c, nl2;
    logic [FB+1:0] tr_c, tb_c, hue_e;
    logic [FB:0]   p_c;

    always_comb
    begin
        nl2 = {1'b0, nl_b_reg, 1'b0};
        if ({1'b0, nl_b_reg} < HALF)
            q_c = {2'b0, nl_b_reg} + {2'b0, m_b_reg};
        else
            q_c = {2'b0, nl_b_reg} + {2'b0, sat_b_reg} - {2'b0, m_b_reg};
        if (q_c > {1'b0, ONE})
            q_c = {1'b0, ONE};
        if (q_c > nl2)
            q_c = nl2;
        if (q_c < {2'b0, nl_b_reg})
            q_c = {2'b0, nl_b_reg};
        p_c   = nl2[FB:0] - q_c[FB:0];
        hue_e = {2'b0, hue_b_reg};
        tr_c  = hue_e + THIRD;
        if (tr_c >= ONE)
            tr_c = tr_c - ONE;
        tb_c  = (hue_e >= THIRD) ? (hue_e - THIRD) : (hue_e + ONE - THIRD);
    end

    logic [FB:0]   q_c_reg, p_c_reg;
    logic [FB-1:0] t_c_reg [3];

    always_ff @(posedge clk)
    begin
        if (en[SC])
        begin
            q_c_reg    <= q_c[FB:0];
            p_c_reg    <= p_c;
            t_c_reg[0] <= tr_c[FB-1:0];
            t_c_reg[1] <= hue_b_reg;
            t_c_reg[2] <= tb_c[FB-1:0];
        end
    end

    // stage d: segment and ramp product per channel
    logic [FB:0]     span;
    hla_pkg::seg_t   seg_d [3];
    logic [FB-1:0]   tt_d [3];
    logic [2*FB:0]   ramp_d [3];
    logic [2*FB+3:0] ramp6_d [3];

    assign span = q_c_reg - p_c_reg;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            if ({2'b0, t_c_reg[c]} < SIXTH)
                seg_d[c] = hla_pkg::SEG_RISE;
            else if ({2'b0, t_c_reg[c]} < HALF)
                seg_d[c] = hla_pkg::SEG_TOP;
            else if ({2'b0, t_c_reg[c]} < TWO3)
                seg_d[c] = hla_pkg::SEG_FALL;
            else
                seg_d[c] = hla_pkg::SEG_LOW;
            tt_d[c]    = (seg_d[c] == hla_pkg::SEG_RISE) ? t_c_reg[c]
                                                         : (TWO3[FB-1:0] - t_c_reg[c]);
            ramp_d[c]  = span * tt_d[c];
            ramp6_d[c] = ({3'b0, ramp_d[c]} << 2) + ({3'b0, ramp_d[c]} << 1);
        end
    end

    hla_pkg::seg_t seg_d_reg [3];
    logic [FB+3:0] ramp_d_reg [3];
    logic [FB:0]   q_d_reg, p_d_reg;

    always_ff @(posedge clk)
    begin
        if (en[SD])
        begin
            for (int c = 0; c < 3; c++)
            begin
                seg_d_reg[c]  <= seg_d[c];
                ramp_d_reg[c] <= ramp6_d[c][2*FB+3:FB];
            end
            q_d_reg <= q_c_reg;
            p_d_reg <= p_c_reg;
        end
    end

    // stage e: channel value, scale to 8 bits, clamp
    logic [FB+3:0]  chan_e [3];
    logic [FB+11:0] scaled_e [3];
    logic [11:0]    byte_e [3];
    logic [7:0]     out_e [3];

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            case (seg_d_reg[c])
                hla_pkg::SEG_RISE,
                hla_pkg::SEG_FALL: chan_e[c] = {3'b0, p_d_reg} + ramp_d_reg[c];
                hla_pkg::SEG_TOP:  chan_e[c] = {3'b0, q_d_reg};
                default:           chan_e[c] = {3'b0, p_d_reg};
            endcase
            scaled_e[c] = ({8'b0, chan_e[c]} << 8) - {8'b0, chan_e[c]};
            byte_e[c]   = scaled_e[c][FB+11:FB];
            out_e[c]    = (byte_e[c] > 12'd255) ? 8'd255 : byte_e[c][7:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[SE])
        begin
            red_out   <= out_e[0];
            green_out <= out_e[1];
            blue_out  <= out_e[2];
        end
    end

endmodule

// ----- src/hla_checker.sv -----
module hla_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       pready,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] red_out,
    input logic [7:0] green_out,
    input logic [7:0] blue_out
);

    // held result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // held result keeps its value
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(red_out) && $stable(green_out) && $stable(blue_out))
        else $error("result changed while stalled");

    // with no result waiting the pipeline always takes a request
    a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with empty output");

    // input only stalls behind a stalled result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output stall");

    // register port never waits
    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready low");

endmodule

bind hsl_lightness_adjust hla_checker u_hla_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .pready    (pready),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .red_out   (red_out),
    .green_out (green_out),
    .blue_out  (blue_out)
);

// ----- bench/hsl_lightness_adjust_test.sv -----
module hsl_lightness_adjust_test;

    localparam int FB = hla_pkg::FRAC_BITS_DEF;
    localparam longint ONE = longint'(1) << FB;
    localparam int LATENCY = FB + 7;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } pixel_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  red_in = '0;
    logic [7:0]  green_in = '0;
    logic [7:0]  blue_in = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  red_out;
    logic [7:0]  green_out;
    logic [7:0]  blue_out;

    // shadow of the configuration registers
    hla_pkg::mode_t cur_mode;
    logic [16:0]    cur_amount;

    pixel_t pending_px[$];
    pixel_t adjusted_px[$];
    int     error_count = 0;
    int     in_gap = 0;
    int     out_gap = 0;
    logic   feed_on;

    hsl_lightness_adjust i_dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_stall(in_stall),
        .red_in(red_in), .green_in(green_in), .blue_in(blue_in),
        .out_valid(out_valid), .out_stall(out_stall),
        .red_out(red_out), .green_out(green_out), .blue_out(blue_out)
    );

    always #6 clk = ~clk;

    // one channel from the hue position
    function automatic logic [7:0] hue_channel(longint p, longint q, longint t);
        longint c;
        longint span;
        span = q - p;
        if (t < ONE / 6)
            c = p + ((span * 6 * t) >> FB);
        else if (t < ONE / 2)
            c = q;
        else if (t < (2 * ONE) / 3)
            c = p + ((span * 6 * ((2 * ONE) / 3 - t)) >> FB);
        else
            c = p;
        c = (c * 255) >> FB;
        return (c > 255) ? 8'd255 : c[7:0];
    endfunction

    // rgb -> hsl, lightness change, hsl -> rgb
    function automatic pixel_t adjust_pixel(pixel_t px);
        longint r, g, b, mx, mn, d, sum, lt, sat, hue, amt, nl, q, p, num, tr, tb;
        pixel_t res;
        r = px.r; g = px.g; b = px.b;
        mx = r; mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        d = mx - mn;
        sum = mx + mn;
        lt = (sum << FB) / 510;
        sat = 0;
        hue = 0;
        if (d != 0)
        begin
            sat = (sum > 255) ? (d << FB) / (510 - sum) : (d << FB) / sum;
            if (mx == r)
                num = (g >= b) ? (g - b) : (6 * d - (b - g));
            else if (mx == g)
                num = 2 * d + b - r;
            else
                num = 4 * d + r - g;
            hue = (num << FB) / (6 * d);
            if (hue >= ONE)
                hue -= ONE;
        end
        amt = (cur_amount > 17'd65536) ? 65536 : cur_amount;
        amt = (FB >= 16) ? (amt << (FB - 16)) : (amt >> (16 - FB));
        case (cur_mode)
            hla_pkg::MODE_SET:     nl = amt;
            hla_pkg::MODE_DARKEN:  nl = (lt * (ONE - amt)) >> FB;
            hla_pkg::MODE_LIGHTEN: nl = lt + (((ONE - lt) * amt) >> FB);
            default:               nl = lt;
        endcase
        if (nl > ONE)
            nl = ONE;
        if (nl < ONE / 2)
            q = (nl * (ONE + sat)) >> FB;
        else
            q = nl + sat - ((nl * sat) >> FB);
        if (q > ONE)
            q = ONE;
        if (q > 2 * nl)
            q = 2 * nl;
        if (q < nl)
            q = nl;
        p = 2 * nl - q;
        tr = hue + ONE / 3;
        if (tr >= ONE)
            tr -= ONE;
        tb = (hue >= ONE / 3) ? hue - ONE / 3 : hue + ONE - ONE / 3;
        res.r = hue_channel(p, q, tr);
        res.g = hue_channel(p, q, hue);
        res.b = hue_channel(p, q, tb);
        return res;
    endfunction

    task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    // apb write, setup then access
    task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == 3'd0)
            cur_mode = hla_pkg::mode_t'(data[1:0]);
        else if (addr == 3'd4)
            cur_amount = data[16:0];
    endtask

    // request driver
    always @(posedge clk)
    begin
        if (!rst_n || !feed_on)
            in_valid <= 1'b0;
        else if (in_valid && !in_stall)
        begin
            adjusted_px.push_back(adjust_pixel({red_in, green_in, blue_in}));
            in_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
            if (in_gap == 0 && pending_px.size() > 0)
            begin
                {red_in, green_in, blue_in} <= pending_px.pop_front();
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
        else if (!in_valid)
        begin
            if (in_gap > 0)
                in_gap--;
            else if (pending_px.size() > 0)
            begin
                {red_in, green_in, blue_in} <= pending_px.pop_front();
                in_valid <= 1'b1;
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        pixel_t want;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (adjusted_px.size() == 0)
                begin
                    $display("unexpected result %0d %0d %0d", red_out, green_out, blue_out);
                    error_count++;
                end
                else
                begin
                    want = adjusted_px.pop_front();
                    if (red_out !== want.r)
                        report("red", red_out, want.r);
                    if (green_out !== want.g)
                        report("green", green_out, want.g);
                    if (blue_out !== want.b)
                        report("blue", blue_out, want.b);
                end
                out_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
            end
            if (out_gap > 0)
            begin
                out_stall <= 1'b1;
                out_gap--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    task automatic drain();
        while (pending_px.size() > 0 || in_valid || adjusted_px.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    function automatic pixel_t rand_pixel();
        pixel_t px;
        px = 24'($urandom);
        case ($urandom_range(0, 5))
            0: px.g = px.r;
            1: begin px.g = px.r; px.b = px.r; end
            2: px.b = px.r;
            default: ;
        endcase
        return px;
    endfunction

    initial
    begin
        logic [31:0] mode_set[8];
        logic [31:0] amt_set[8];
        clk = 0; rst_n = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        feed_on = 0;
        cur_mode = hla_pkg::MODE_SET; cur_amount = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        feed_on <= 1'b1;

        // directed: reset registers, extremes, greys, ties, all modes
        pending_px.push_back({8'd0, 8'd0, 8'd0});
        pending_px.push_back({8'd255, 8'd255, 8'd255});
        pending_px.push_back({8'd255, 8'd0, 8'd0});
        drain();
        reg_write(3'd0, 32'(hla_pkg::MODE_KEEP));
        reg_write(3'd4, 32'h1FFFF);
        pending_px.push_back({8'd0, 8'd0, 8'd0});
        pending_px.push_back({8'd255, 8'd255, 8'd255});
        pending_px.push_back({8'd128, 8'd128, 8'd128});
        pending_px.push_back({8'd255, 8'd0, 8'd0});
        pending_px.push_back({8'd0, 8'd255, 8'd0});
        pending_px.push_back({8'd0, 8'd0, 8'd255});
        pending_px.push_back({8'd255, 8'd255, 8'd0});
        pending_px.push_back({8'd0, 8'd255, 8'd255});
        pending_px.push_back({8'd255, 8'd0, 8'd255});
        pending_px.push_back({8'd10, 8'd20, 8'd240});
        pending_px.push_back({8'd200, 8'd10, 8'd90});
        drain();
        for (int m = 0; m < 3; m++)
        begin
            reg_write(3'd0, m);
            reg_write(3'd4, (m == 0) ? 32'h10000 : 32'h08000);
            pending_px.push_back({8'd255, 8'd128, 8'd0});
            pending_px.push_back({8'd255, 8'd255, 8'd255});
            pending_px.push_back({8'd1, 8'd0, 8'd2});
            drain();
        end

        // random phases over several register settings
        mode_set = '{0, 1, 2, 3, 1, 2, 0, 1};
        amt_set = '{0, 32'h10000, 32'h1FFFF, 0, 0, 1, 32'h10001, 32'h0FFFF};
        for (int ph = 0; ph < 16; ph++)
        begin
            if (ph < 8)
            begin
                reg_write(3'd0, mode_set[ph]);
                reg_write(3'd4, amt_set[ph]);
            end
            else
            begin
                reg_write(3'd0, $urandom_range(0, 3) | ($urandom & 32'hFFFFFFFC));
                reg_write(3'd4, ($urandom_range(0, 4) == 0) ? $urandom
                                                            : $urandom_range(0, 65536));
            end
            repeat (96) pending_px.push_back(rand_pixel());
            drain();
        end

        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #6000000;
        $display("RESULT: ERROR");
        $finish;
    end
endmodule
